// File: hdl/animated_color_wave_generator_defines.svh
// Assertion macros for the animated color wave generator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ANIMATED_COLOR_WAVE_GENERATOR_DEFINES_SVH
`define ANIMATED_COLOR_WAVE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ACWG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acwg check failed");
`define ACWG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acwg check failed");
`else
`define ACWG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ACWG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/acwg_pkg.sv
// Shared types and constants of the animated color wave generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package acwg_pkg;

  localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;
  localparam int CHANNEL_COUNT = 4;
  localparam int CHAN_W = 16;
  localparam int TIME_W = 48;
  localparam int FREQ_W = 24;
  localparam int PHASE_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = CHANNEL_COUNT * CHAN_W;

  typedef enum logic [1:0] {
    WAVE_SAW    = 2'd0,
    WAVE_SINE   = 2'd1,
    WAVE_RAISED = 2'd2,
    WAVE_OFF    = 2'd3
  } wave_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_MODE       = 2'd0,
    CFG_FREQUENCY       = 2'd1,
    CFG_BASE_COLOR      = 2'd2,
    CFG_SWING_DIRECTION = 2'd3
  } cfg_reg_t;

  typedef logic [CHANNEL_COUNT-1:0][CHAN_W-1:0] chan_vec_t;

  // Side information that rides along with the sine lookup.
  typedef struct packed {
    logic [1:0]        quad;
    logic signed [15:0] saw;
  } wave_info_t;

endpackage

`default_nettype wire

// File: hdl/animated_color_wave_generator.sv
// Animated color wave generator, top level: config registers and a six-stage pipeline.
// Throughput: one time stamp per cycle; each stage holds when the next one is full,
// so empty slots close up and the input keeps taking items while a result waits.
// Reset: rst_n is synchronous, active low; it empties the pipeline and returns the
// registers to sine mode, 1 Hz, black base color and zero swing.
`timescale 1ns / 1ps
`default_nettype none

`include "animated_color_wave_generator_defines.svh"

module animated_color_wave_generator
  import acwg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_TABLE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port, no read-back.
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [TIME_W-1:0]     in_tdata,   // time_stamp[47:0]
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [CFG_DATA_W-1:0]      out_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic [0:0]                 out_tuser   // animating
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

  // Configuration registers. Writes must only come while the pipeline is empty; the
  // block does not enforce this, and every stage reads them directly without carrying a copy along.
  wave_mode_t        mode_r;
  logic [FREQ_W-1:0] freq_r;
  chan_vec_t         base_r;
  chan_vec_t         swing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= WAVE_SINE;
      freq_r  <= FREQ_W'(65536);
      base_r  <= '0;
      swing_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WAVE_MODE:       mode_r  <= wave_mode_t'(cfg_wdata[1:0]);
        CFG_FREQUENCY:       freq_r  <= cfg_wdata[FREQ_W-1:0];
        CFG_BASE_COLOR:      base_r  <= cfg_wdata;
        CFG_SWING_DIRECTION: swing_r <= cfg_wdata;
      endcase
    end
  end

  // Stages 1 and 2: phase as the fraction of a turn, then the quadrant, the
  // mirrored table index and the sawtooth value.
  logic             ph_valid, ph_ready;
  logic [IDX_W-1:0] ph_idx;
  wave_info_t       ph_info;

  acwg_phase #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_freq (freq_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_time  (in_tdata),
    .out_valid(ph_valid),
    .out_ready(ph_ready),
    .out_idx  (ph_idx),
    .out_info (ph_info)
  );

  // Stage 3: quarter-wave table lookup; the ROM read data is the stage register.
  logic              rom_valid, rom_ready;
  logic [CHAN_W-1:0] rom_sine;
  wave_info_t        rom_info;

  acwg_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (ph_valid),
    .in_ready (ph_ready),
    .in_idx   (ph_idx),
    .in_info  (ph_info),
    .out_valid(rom_valid),
    .out_ready(rom_ready),
    .out_sine (rom_sine),
    .out_info (rom_info)
  );

  // Stages 4 to 6: factor by mode, four signed products, then rounding, the
  // add to the base color and the clamp into the output register.
  chan_vec_t mix_chan;
  logic      mix_anim;

  acwg_mix u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_mode     (mode_r),
    .cfg_base     (base_r),
    .cfg_swing    (swing_r),
    .in_valid     (rom_valid),
    .in_ready     (rom_ready),
    .in_sine      (rom_sine),
    .in_info      (rom_info),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_chan     (mix_chan),
    .out_animating(mix_anim)
  );

  assign out_tdata = mix_chan;
  assign out_tuser = mix_anim;

  // The input only stalls when every stage is full and the result is held.
  `ACWG_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !in_tready, out_tvalid && !out_tready)
  // Every delivered channel lies within 0..1.0 after the clamp.
  `ACWG_ASSERT_IMP(a_channels_clamped, clk, rst_n, out_tvalid, (out_tdata[15:0] <= 16'd32768) && (out_tdata[31:16] <= 16'd32768) && (out_tdata[47:32] <= 16'd32768) && (out_tdata[63:48] <= 16'd32768))

endmodule

`default_nettype wire

// File: hdl/acwg_phase.sv
// Phase stages: frequency times time, then quadrant, table index and sawtooth.
// Depends on acwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acwg_phase
  import acwg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_TABLE_DEPTH,
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [FREQ_W-1:0] cfg_freq,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [TIME_W-1:0] in_time,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IDX_W-1:0]       out_idx,
  output wave_info_t             out_info
);

  localparam int PROD_W = PHASE_W - 2 + IDX_W;
  localparam logic [PROD_W-1:0] DEPTH_V = PROD_W'(SINE_TABLE_DEPTH);
  localparam logic [PROD_W-1:0] HALF_STEP = PROD_W'(1) << (PHASE_W - 3);

  logic               v1_r, v2_r;
  logic               rdy1, rdy2;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PROD_W-1:0]  scaled;
  logic [IDX_W-1:0]   idx_raw, idx_nxt, idx_r;
  wave_info_t         info_nxt, info_r;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Only the fraction of a turn is kept, so the low 32 bits of time suffice.
  assign phase_nxt = PHASE_W'(cfg_freq) * in_time[PHASE_W-1:0];

  always_comb begin
    scaled  = PROD_W'(phase_r[PHASE_W-3:0]) * DEPTH_V + HALF_STEP;
    idx_raw = scaled[PROD_W-1:PHASE_W-2];
    idx_nxt = phase_r[PHASE_W-2] ? (DEPTH_V[IDX_W-1:0] - idx_raw) : idx_raw;
    info_nxt.quad = phase_r[PHASE_W-1:PHASE_W-2];
    info_nxt.saw  = signed'({~phase_r[PHASE_W-1], phase_r[PHASE_W-2:PHASE_W-16]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) phase_r <= phase_nxt;
    if (rdy2 && v1_r) begin
      idx_r  <= idx_nxt;
      info_r <= info_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_idx   = idx_r;
  assign out_info  = info_r;

endmodule

`default_nettype wire

// File: hdl/acwg_sine_rom.sv
// Quarter-wave sine ROM stage with registered read data.
// Depends on acwg_pkg; the table is built at elaboration.
`timescale 1ns / 1ps
`default_nettype none

module acwg_sine_rom
  import acwg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_TABLE_DEPTH,
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [IDX_W-1:0] in_idx,
  input  wire wave_info_t       in_info,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [CHAN_W-1:0]     out_sine,
  output wave_info_t            out_info
);

  localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;
  localparam int SERIES_TERMS = 12;
  localparam logic [63:0] SERIES_DIV [1:SERIES_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

  typedef logic [CHAN_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

  // Taylor series in Q.28 evaluated once per entry, rounded to Q1.15.
  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] x, x2, term, sum, v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q28 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 28;
      term = x;
      sum  = x;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        term = ((term * x2) >> 28) / SERIES_DIV[n];
        if (n % 2 == 1) sum = sum - term;
        else            sum = sum + term;
      end
      v = (sum * 64'd32768 + (64'd1 << 27)) >> 28;
      if (v > 64'd32768) v = 64'd32768;
      tbl[k] = v[CHAN_W-1:0];
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic       v_r;
  logic       rdy;
  logic [CHAN_W-1:0] sine_r;
  wave_info_t info_r;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (rdy) v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      sine_r <= SINE_ROM[in_idx];
      info_r <= in_info;
    end
  end

  assign out_valid = v_r;
  assign out_sine  = sine_r;
  assign out_info  = info_r;

endmodule

`default_nettype wire

// File: hdl/acwg_mix.sv
// Mix stages: wave factor by mode, per-channel products, rounding and clamp.
// Depends on acwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acwg_mix
  import acwg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wave_mode_t        cfg_mode,
  input  wire chan_vec_t         cfg_base,
  input  wire chan_vec_t         cfg_swing,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CHAN_W-1:0] in_sine,
  input  wire wave_info_t        in_info,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output chan_vec_t              out_chan,
  output logic                   out_animating
);

  localparam logic signed [19:0] FULL_SCALE = 20'sd32768;

  logic v4_r, v5_r, v6_r;
  logic rdy4, rdy5, rdy6;

  logic signed [16:0] sine_val;
  logic signed [17:0] raised;
  logic signed [16:0] factor_nxt, factor_r;
  logic               anim_nxt, anim4_r, anim5_r, anim6_r;

  logic signed [32:0] prod_nxt [CHANNEL_COUNT];
  logic signed [32:0] prod_r   [CHANNEL_COUNT];
  logic signed [33:0] rnd      [CHANNEL_COUNT];
  logic signed [19:0] sum      [CHANNEL_COUNT];
  chan_vec_t          chan_nxt, chan_r;

  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign in_ready = rdy4;

  always_comb begin
    sine_val = signed'({1'b0, in_sine});
    if (in_info.quad[1]) sine_val = -sine_val;
    raised     = 18'(sine_val) + 18'sd32768;
    factor_nxt = 17'sd0;
    anim_nxt   = 1'b1;
    unique case (cfg_mode)
      WAVE_SAW:    factor_nxt = 17'(in_info.saw);
      WAVE_SINE:   factor_nxt = sine_val;
      WAVE_RAISED: factor_nxt = signed'(raised[17:1]);
      WAVE_OFF: begin
        factor_nxt = 17'sd0;
        anim_nxt   = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      prod_nxt[c] = 33'(factor_r) * 33'(signed'(cfg_swing[c]));
    end
  end

  // Round half up by a floor shift of the biased product, then clamp to 0..1.0.
  always_comb begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      rnd[c] = 34'(prod_r[c]) + 34'sd16384;
      sum[c] = signed'({4'd0, cfg_base[c]}) + 20'(signed'(rnd[c][33:15]));
      if (sum[c] < 20'sd0)            chan_nxt[c] = '0;
      else if (sum[c] > FULL_SCALE)   chan_nxt[c] = FULL_SCALE[CHAN_W-1:0];
      else                            chan_nxt[c] = sum[c][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      factor_r <= factor_nxt;
      anim4_r  <= anim_nxt;
    end
    if (rdy5 && v4_r) begin
      prod_r  <= prod_nxt;
      anim5_r <= anim4_r;
    end
    if (rdy6 && v5_r) begin
      chan_r  <= chan_nxt;
      anim6_r <= anim5_r;
    end
  end

  assign out_valid     = v6_r;
  assign out_chan      = chan_r;
  assign out_animating = anim6_r;

endmodule

`default_nettype wire

// File: tb/sv/animated_color_wave_generator_test.sv
// Self-checking testbench for the animated color wave generator.
// Drives time stamps, predicts each RGBA result from its own fixed point model and
// compares every transfer; depends only on acwg_pkg and the block's top module.
`timescale 1ns / 1ps

module animated_color_wave_generator_test;
  import acwg_pkg::*;

  // Depth of the quarter-wave table inside the block and its pipeline length.
  localparam int SINE_DEPTH = DEFAULT_SINE_TABLE_DEPTH;
  localparam int PIPE_LATENCY = 6;
  localparam int TARGET_ITEMS = 1600;
  localparam int CYCLE_LIMIT = 400000;
  // pi/2 in Q4.28 and the number of Taylor terms used to build the table.
  localparam longint unsigned HALF_PI_Q28 = 64'd421657428;
  localparam int TAYLOR_TERMS = 12;
  localparam int UNITY = 32768;

  // One expected result: the four clamped channels and the animating flag.
  typedef struct packed {
    chan_vec_t colors;
    logic      animating;
  } color_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TIME_W-1:0]     in_tdata = '0;   // time_stamp[47:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [CFG_DATA_W-1:0] out_tdata;       // red_out, green_out, blue_out, alpha_out
  logic [0:0]            out_tuser;       // animating

  animated_color_wave_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Local copy of the configuration registers, kept in step with every write.
  wave_mode_t  mode_shadow = WAVE_SINE;
  logic [23:0] freq_shadow = 24'h010000;
  chan_vec_t   base_shadow = '0;
  chan_vec_t   swing_shadow = '0;

  int unsigned sine_quarter_lut [0:SINE_DEPTH];

  logic [TIME_W-1:0] pending_stamps[$];
  color_result_t     expected_colors[$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  accept_stall = 0;
  // When set, neither side idles; used for some phases to keep the pipeline full.
  bit  steady_run = 1'b0;

  // The table is built the same way the block's constant is defined: a Taylor
  // series for sin(x) in Q28, rounded to Q1.15 and capped at 1.0.
  function automatic void build_sine_lut();
    longint unsigned x, x2, term, sum, v;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x = (HALF_PI_Q28 * longint'(k) + longint'(SINE_DEPTH / 2)) / longint'(SINE_DEPTH);
      x2 = (x * x) >> 28;
      term = x;
      sum = x;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = ((term * x2) >> 28) / (longint'(2 * n) * longint'(2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32768 + (64'd1 << 27)) >> 28;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      sine_quarter_lut[k] = int'(v);
    end
  endfunction

  // Sine of a Q.32 phase: quadrant from the top two bits, rounded table index from
  // the rest; odd quadrants run the table backward, the lower half is negated.
  function automatic int sine_at(logic [31:0] phase);
    longint unsigned idx;
    int value;
    idx = ({34'd0, phase[29:0]} * longint'(SINE_DEPTH) + (64'd1 << 29)) >> 30;
    if (idx > longint'(SINE_DEPTH)) begin
      idx = longint'(SINE_DEPTH);
    end
    if (phase[30]) begin
      idx = longint'(SINE_DEPTH) - idx;
    end
    value = int'(sine_quarter_lut[idx]);
    return phase[31] ? -value : value;
  endfunction

  function automatic color_result_t predict_color(logic [TIME_W-1:0] stamp);
    color_result_t res;
    logic [63:0] product;
    logic [31:0] phase;
    int factor;
    longint base, swing, delta, sum;
    // Only the fractional turn matters, so the low 32 bits of the product suffice.
    product = {40'd0, freq_shadow} * {16'd0, stamp};
    phase = product[31:0];
    res.animating = 1'b1;
    case (mode_shadow)
      WAVE_SAW: begin
        factor = int'({16'd0, phase[31:16]}) - UNITY;
      end
      WAVE_SINE: begin
        factor = sine_at(phase);
      end
      WAVE_RAISED: begin
        factor = (sine_at(phase) + UNITY) >>> 1;
      end
      default: begin
        factor = 0;
        res.animating = 1'b0;
      end
    endcase
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      base = longint'({48'd0, base_shadow[c]});
      swing = longint'($signed(swing_shadow[c]));
      // Round to nearest with ties toward plus infinity, as a floor of x + 1/2.
      delta = (longint'(factor) * swing + 64'sd16384) >>> 15;
      sum = base + delta;
      if (sum < 0) begin
        sum = 0;
      end else if (sum > UNITY) begin
        sum = UNITY;
      end
      res.colors[c] = sum[15:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_color(chan_vec_t got, logic got_anim);
    color_result_t want;
    if (expected_colors.size() == 0) begin
      report_mismatch($sformatf("result transfer with nothing expected, data %h", got));
    end else begin
      want = expected_colors.pop_front();
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        if (got[c] !== want.colors[c]) begin
          report_mismatch($sformatf("channel %0d got %0d expected %0d",
                                    c, got[c], want.colors[c]));
        end
      end
      if (got_anim !== want.animating) begin
        report_mismatch($sformatf("animating got %b expected %b", got_anim, want.animating));
      end
    end
  endtask

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Input driver: launches the next pending time stamp, holds it until the
  // transfer, and records the prediction at the edge where the transfer happens.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_colors.push_back(predict_color(in_tdata));
      end
      if (in_tvalid && !in_tready) begin
        // Hold the item until the block takes it.
      end else if (send_gap > 0 && !steady_run) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_stamps.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_stamps.pop_front();
        send_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: random back pressure, each transfer checked against the
  // oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      accept_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_color(chan_vec_t'(out_tdata), out_tuser[0]);
      end
      if (steady_run) begin
        out_tready <= 1'b1;
      end else if (accept_stall > 0) begin
        accept_stall <= accept_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          accept_stall <= pick_gap();
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("animated_color_wave_generator test failed");
      $finish;
    end
  end

  // Registers may only change while the pipeline is empty, so wait until every
  // item has been taken and answered, then let the pipeline run dry.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_stamps.size() != 0 || in_tvalid || expected_colors.size() != 0);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_WAVE_MODE:       mode_shadow = wave_mode_t'(value[1:0]);
      CFG_FREQUENCY:       freq_shadow = value[23:0];
      CFG_BASE_COLOR:      base_shadow = chan_vec_t'(value);
      CFG_SWING_DIRECTION: swing_shadow = chan_vec_t'(value);
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // The mode and frequency writes carry random bits above the register width,
  // which the block must drop.
  task automatic write_all(wave_mode_t mode, logic [23:0] freq, chan_vec_t base,
                           chan_vec_t swing);
    write_reg(CFG_WAVE_MODE, {$urandom, $urandom} & ~64'h3 | {62'd0, mode});
    write_reg(CFG_FREQUENCY, {$urandom, $urandom} & ~64'hFFFFFF | {40'd0, freq});
    write_reg(CFG_BASE_COLOR, base);
    write_reg(CFG_SWING_DIRECTION, swing);
  endtask

  function automatic logic [15:0] pick_base_channel();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(0, UNITY));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_swing_channel();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 2000)) - 16'd1000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_frequency();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 24'h040000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_stamp();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return 48'hFFFF_FFFF_FFFF;
      1: return 48'd0;
      2, 3: return {32'd0, raw[15:0]};
      // Land right at or just short of a quarter turn for 1 Hz style rates.
      4: return {raw[47:16], raw[15:14], raw[0] ? 14'h3FFF : 14'h0000};
      default: return raw[TIME_W-1:0];
    endcase
  endfunction

  initial begin
    int sent;
    int count;
    chan_vec_t base;
    chan_vec_t swing;

    build_sine_lut();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Values straight out of reset: sine at 1 Hz with a black base and no swing.
    pending_stamps.push_back(48'd0);
    pending_stamps.push_back(48'h4000);
    pending_stamps.push_back(48'hFFFF_FFFF_FFFF);
    wait_drained();

    // At 1 Hz the phase is the low 16 bits of the stamp shifted up, so stamps pick
    // quadrant edges directly. Channels cover zero base, full scale, a base beyond
    // 1.0, and both swing extremes, so both clamps are reached.
    base = {16'hFFFF, 16'h8000, 16'h4000, 16'h0000};
    swing = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    write_all(WAVE_SINE, 24'h010000, base, swing);
    pending_stamps.push_back(48'h0000);
    pending_stamps.push_back(48'h3FFF);  // index rounds up to the table end
    pending_stamps.push_back(48'h4000);
    pending_stamps.push_back(48'h8000);
    pending_stamps.push_back(48'hC000);  // sine of -1 against the most negative swing
    pending_stamps.push_back(48'hBFFF);
    pending_stamps.push_back(48'h2000);
    wait_drained();

    write_all(WAVE_SAW, 24'h010000, base, swing);
    pending_stamps.push_back(48'h0000);
    pending_stamps.push_back(48'h8000);
    pending_stamps.push_back(48'hFFFF);
    pending_stamps.push_back(48'hFFFF_FFFF_FFFF);
    wait_drained();

    write_all(WAVE_RAISED, 24'h010000, base, swing);
    pending_stamps.push_back(48'h4000);
    pending_stamps.push_back(48'hC000);
    pending_stamps.push_back(48'h0000);
    wait_drained();

    // Off mode gives the clamped base color with the flag cleared.
    write_all(WAVE_OFF, 24'h010000, base, swing);
    pending_stamps.push_back(48'h1234);
    pending_stamps.push_back(48'hFFFF_FFFF_FFFF);
    wait_drained();

    write_all(WAVE_SINE, 24'hFFFFFF, base, swing);
    pending_stamps.push_back(48'hFFFF_FFFF_FFFF);
    pending_stamps.push_back(48'd1);
    wait_drained();

    // Random phases: a fresh register setting each time, then a burst of stamps.
    sent = 0;
    while (sent < TARGET_ITEMS) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        base[c] = pick_base_channel();
        swing[c] = pick_swing_channel();
      end
      write_all(wave_mode_t'($urandom_range(0, 3)), pick_frequency(), base, swing);
      steady_run = ($urandom_range(0, 3) == 0);
      count = $urandom_range(60, 140);
      for (int i = 0; i < count; i++) begin
        pending_stamps.push_back(pick_stamp());
      end
      sent += count;
      wait_drained();
      steady_run = 1'b0;
    end

    repeat (4 * PIPE_LATENCY) @(negedge clk);
    if (mismatch_count == 0 && expected_colors.size() == 0) begin
      $display("animated_color_wave_generator test passed");
    end else begin
      $display("animated_color_wave_generator test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/acwg_pkg.sv
hdl/acwg_phase.sv
hdl/acwg_sine_rom.sv
hdl/acwg_mix.sv
hdl/animated_color_wave_generator.sv
tb/sv/animated_color_wave_generator_test.sv
